// ===== src/nfa_pkg.sv =====
`default_nettype none
package nfa_pkg;

  localparam int unsigned NUM_BLOCKS_DEF       = 65536;
  localparam int unsigned FIRST_DATA_BLOCK_DEF = 129;

  // used map is held in memory words of this many block bits
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = $clog2(WORD_W);
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned CNT_W  = 17;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_GRANTED = 2'd0;
  localparam logic [1:0] ST_FREED   = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

endpackage
`default_nettype wire

// ===== src/nfa_ram.sv =====
`default_nettype none
module nfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/nfa_word_pick.sv =====
`default_nettype none
module nfa_word_pick
  import nfa_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS       = NUM_BLOCKS_DEF,
  parameter int unsigned FIRST_DATA_BLOCK = FIRST_DATA_BLOCK_DEF,
  parameter int unsigned AW               = 11
) (
  input  wire logic [WORD_W-1:0] word_i,
  input  wire logic [AW-1:0]     addr_i,
  input  wire logic              first_i,
  input  wire logic [BIT_W-1:0]  start_bit_i,
  output logic                   found_o,
  output logic      [BIT_W-1:0]  bit_o
);

  localparam int unsigned FIRST_WORD = FIRST_DATA_BLOCK / WORD_W;
  localparam int unsigned LAST_WORD  = (NUM_BLOCKS - 1) / WORD_W;
  localparam int unsigned LO_BIT     = FIRST_DATA_BLOCK % WORD_W;
  localparam int unsigned HI_BIT     = (NUM_BLOCKS - 1) % WORD_W;

  logic [WORD_W-1:0] avail;
  logic              in_first_word;
  logic              in_last_word;

  assign in_first_word = (addr_i == AW'(FIRST_WORD));
  assign in_last_word  = (addr_i == AW'(LAST_WORD));

  // free bits inside the data region and at or after the scan start
  always_comb begin
    avail = ~word_i;
    for (int unsigned b = 0; b < WORD_W; b++) begin
      if (in_first_word && (b < LO_BIT)) begin
        avail[b] = 1'b0;
      end
      if (in_last_word && (b > HI_BIT)) begin
        avail[b] = 1'b0;
      end
      if (first_i && (BIT_W'(b) < start_bit_i)) begin
        avail[b] = 1'b0;
      end
    end
  end

  // lowest free bit wins
  always_comb begin
    bit_o = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        bit_o = BIT_W'(b);
      end
    end
  end

  assign found_o = |avail;

endmodule
`default_nettype wire

// ===== src/next_fit_block_allocator_core.sv =====
// an out-of-region free or empty-pool alloc goes straight to the output register;
// an in-region free reads its map word; an alloc scans one 32-block map word per cycle
// throughput: one request at a time, bounded by the single read port of the map memory
// reset: asynchronous, then a clearing pass writes zero to every map word,
// one word a cycle (NUM_BLOCKS/32 words, 2048 by default), with s_axis_tready_o low
`default_nettype none
module next_fit_block_allocator_core
  import nfa_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS       = NUM_BLOCKS_DEF,
  parameter int unsigned FIRST_DATA_BLOCK = FIRST_DATA_BLOCK_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [15:0] block_index
  input  wire logic        s_axis_tuser_i,   // [0] op
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [39:0] m_axis_tdata_o,   // [15:0] granted_block, [32:16] free_left
  output logic      [1:0]  m_axis_tuser_o    // [1:0] status
);

  localparam int unsigned NUM_WORDS   = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW          = $clog2(NUM_WORDS);
  localparam int unsigned FIRST_WORD  = FIRST_DATA_BLOCK / WORD_W;
  localparam int unsigned LAST_WORD   = NUM_WORDS - 1;
  localparam int unsigned DATA_BLOCKS = NUM_BLOCKS - FIRST_DATA_BLOCK;

  localparam logic [CNT_W-1:0] NUM_LIM   = CNT_W'(NUM_BLOCKS);
  localparam logic [CNT_W-1:0] FIRST_LIM = CNT_W'(FIRST_DATA_BLOCK);
  localparam logic [CNT_W-1:0] DATA_CNT  = CNT_W'(DATA_BLOCKS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FCHK = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] last_q, last_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             clr_q;
  logic [AW-1:0]    clr_addr_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [AW-1:0]    wa_q, wa_d;
  logic             first_q, first_d;

  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_blk_q, out_blk_d;
  logic [1:0]       out_st_q, out_st_d;
  logic [CNT_W-1:0] out_left_q, out_left_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic              found;
  logic [BIT_W-1:0]  pick_bit;
  logic [WORD_W-1:0] pick_mask, free_mask;

  logic             s_fire, out_free;
  logic [IDX_W-1:0] in_idx;
  logic             in_region;
  logic [CNT_W-1:0] cur1;
  logic [IDX_W-1:0] start_cur;
  logic [AW-1:0]    next_wa;
  logic [IDX_W-1:0] grant_idx;

  nfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  nfa_word_pick #(
    .NUM_BLOCKS       (NUM_BLOCKS),
    .FIRST_DATA_BLOCK (FIRST_DATA_BLOCK),
    .AW               (AW)
  ) u_pick (
    .word_i      (ram_rdata),
    .addr_i      (wa_q),
    .first_i     (first_q),
    .start_bit_i (idx_q[BIT_W-1:0]),
    .found_o     (found),
    .bit_o       (pick_bit)
  );

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && !clr_q && out_free;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  assign in_idx    = s_axis_tdata_i;
  assign in_region = ({1'b0, in_idx} >= FIRST_LIM) && ({1'b0, in_idx} < NUM_LIM);

  // scan starts after the last grant, or at the region start if that falls outside
  assign cur1      = {1'b0, last_q} + CNT_W'(1);
  assign start_cur = ((cur1 >= FIRST_LIM) && (cur1 < NUM_LIM)) ? cur1[IDX_W-1:0]
                                                              : IDX_W'(FIRST_DATA_BLOCK);
  assign next_wa   = (wa_q == AW'(LAST_WORD)) ? AW'(FIRST_WORD) : wa_q + AW'(1);
  assign grant_idx = IDX_W'({wa_q, pick_bit});

  assign pick_mask = WORD_W'(1) << pick_bit;
  assign free_mask = WORD_W'(1) << idx_q[BIT_W-1:0];

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    wa_d        = wa_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_blk_d   = out_blk_q;
    out_st_d    = out_st_q;
    out_left_d  = out_left_q;
    ram_re      = 1'b0;
    ram_raddr   = wa_q;
    ram_we      = 1'b0;
    ram_waddr   = wa_q;
    ram_wdata   = ram_rdata;

    if (clr_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser_i == OP_FREE) begin
            if (in_region) begin
              idx_d     = in_idx;
              ram_re    = 1'b1;
              ram_raddr = in_idx[BIT_W +: AW];
              state_d   = S_FCHK;
            end else begin
              out_valid_d = 1'b1;
              out_blk_d   = '0;
              out_st_d    = ST_BADFREE;
              out_left_d  = cnt_q;
            end
          end else if (cnt_q == '0) begin
            out_valid_d = 1'b1;
            out_blk_d   = '0;
            out_st_d    = ST_EMPTY;
            out_left_d  = cnt_q;
          end else begin
            idx_d     = start_cur;
            wa_d      = start_cur[BIT_W +: AW];
            first_d   = 1'b1;
            ram_re    = 1'b1;
            ram_raddr = start_cur[BIT_W +: AW];
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (found) begin
          // read data holds while the result waits for the output register
          if (out_free) begin
            ram_we      = 1'b1;
            ram_waddr   = wa_q;
            ram_wdata   = ram_rdata | pick_mask;
            last_d      = grant_idx;
            cnt_d       = cnt_q - CNT_W'(1);
            out_valid_d = 1'b1;
            out_blk_d   = grant_idx;
            out_st_d    = ST_GRANTED;
            out_left_d  = cnt_q - CNT_W'(1);
            state_d     = S_IDLE;
          end
        end else begin
          wa_d      = next_wa;
          first_d   = 1'b0;
          ram_re    = 1'b1;
          ram_raddr = next_wa;
        end
      end
      S_FCHK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (|(ram_rdata & free_mask)) begin
            ram_we     = 1'b1;
            ram_waddr  = wa_q;
            ram_wdata  = ram_rdata & ~free_mask;
            cnt_d      = (cnt_q < DATA_CNT) ? cnt_q + CNT_W'(1) : cnt_q;
            out_blk_d  = idx_q;
            out_st_d   = ST_FREED;
            out_left_d = (cnt_q < DATA_CNT) ? cnt_q + CNT_W'(1) : cnt_q;
          end else begin
            out_blk_d  = '0;
            out_st_d   = ST_BADFREE;
            out_left_d = cnt_q;
          end
        end
        ram_waddr = idx_q[BIT_W +: AW];
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= IDX_W'(FIRST_DATA_BLOCK - 1);
      cnt_q       <= DATA_CNT;
      out_valid_q <= 1'b0;
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(LAST_WORD)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    wa_q       <= wa_d;
    first_q    <= first_d;
    out_blk_q  <= out_blk_d;
    out_st_q   <= out_st_d;
    out_left_q <= out_left_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_left_q, out_blk_q};
  assign m_axis_tuser_o  = out_st_q;

endmodule
`default_nettype wire

// ===== src/nfa_checker.sv =====
`default_nettype none
module nfa_checker
  import nfa_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS       = NUM_BLOCKS_DEF,
  parameter int unsigned FIRST_DATA_BLOCK = FIRST_DATA_BLOCK_DEF
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [15:0] s_axis_tdata_i,
  input wire logic        s_axis_tuser_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [39:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o
);

  logic s_fire;
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;

  // a free inside the data region waits on a map read
  a_free_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (s_axis_tuser_i == OP_FREE) &&
     ({1'b0, s_axis_tdata_i} >= 17'(FIRST_DATA_BLOCK)) &&
     ({1'b0, s_axis_tdata_i} < 17'(NUM_BLOCKS))) |=> !s_axis_tready_o)
    else $error("input accepted while a free lookup was pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled output word changed");

  a_grant_in_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == ST_GRANTED)) |->
      (({1'b0, m_axis_tdata_o[15:0]} >= 17'(FIRST_DATA_BLOCK)) &&
       ({1'b0, m_axis_tdata_o[15:0]} < 17'(NUM_BLOCKS))))
    else $error("granted block outside the data region");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == ST_EMPTY)) |->
      ((m_axis_tdata_o[15:0] == 16'd0) && (m_axis_tdata_o[32:16] == 17'd0)))
    else $error("empty pool reported with nonzero block or free count");

  a_badfree_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == ST_BADFREE)) |->
      (m_axis_tdata_o[15:0] == 16'd0))
    else $error("bad free reported with nonzero block");

endmodule

bind next_fit_block_allocator_core nfa_checker #(
  .NUM_BLOCKS       (NUM_BLOCKS),
  .FIRST_DATA_BLOCK (FIRST_DATA_BLOCK)
) u_nfa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nfa_pkg::*;

  localparam int unsigned POOL_END    = NUM_BLOCKS_DEF;
  localparam int unsigned FIRST_DATA  = FIRST_DATA_BLOCK_DEF;
  localparam int unsigned DATA_BLOCKS = POOL_END - FIRST_DATA;

  typedef struct packed {
    logic [15:0] blk;
    logic [1:0]  status;
    logic [16:0] free_left;
  } alloc_result_t;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        req_valid  = 1'b0;
  logic        req_ready;
  logic [15:0] req_index  = 16'd0;
  logic        req_op     = OP_ALLOC;
  logic        rsp_valid;
  logic        rsp_ready  = 1'b0;
  logic [39:0] rsp_data;
  logic [1:0]  rsp_status;

  // allocator state as the testbench sees it
  bit          block_used [POOL_END];
  logic [15:0] last_grant;
  logic [16:0] blocks_free;

  alloc_result_t expected_q[$];
  logic [15:0]   live_q[$];
  logic [15:0]   freed_q[$];
  bit            gaps_on = 1'b1;
  int unsigned   mismatches;
  int unsigned   status_seen [4];

  next_fit_block_allocator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_o (req_ready),
    .s_axis_tdata_i  (req_index),
    .s_axis_tuser_i  (req_op),
    .m_axis_tvalid_o (rsp_valid),
    .m_axis_tready_i (rsp_ready),
    .m_axis_tdata_o  (rsp_data),
    .m_axis_tuser_o  (rsp_status)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void predict_request(input logic op, input logic [15:0] index);
    alloc_result_t r;
    int unsigned   pos;
    r = '{blk: 16'd0, status: ST_EMPTY, free_left: 17'd0};
    if (op == OP_ALLOC) begin
      if (blocks_free != 0) begin
        pos = last_grant + 32'd1;
        if (pos < FIRST_DATA || pos >= POOL_END) pos = FIRST_DATA;
        // a free block exists, so the scan always stops
        while (block_used[pos]) begin
          pos++;
          if (pos >= POOL_END) pos = FIRST_DATA;
        end
        block_used[pos] = 1'b1;
        last_grant      = pos[15:0];
        blocks_free     = blocks_free - 17'd1;
        r.blk           = pos[15:0];
        r.status        = ST_GRANTED;
        live_q.push_back(pos[15:0]);
      end
    end else if (index >= FIRST_DATA && index < POOL_END && block_used[index]) begin
      block_used[index] = 1'b0;
      if (blocks_free < DATA_BLOCKS) blocks_free = blocks_free + 17'd1;
      r.blk    = index;
      r.status = ST_FREED;
      freed_q.push_back(index);
      if (freed_q.size() > 64) void'(freed_q.pop_front());
    end else begin
      r.status = ST_BADFREE;
    end
    r.free_left = blocks_free;
    expected_q.push_back(r);
  endfunction

  task automatic push_request(input logic op, input logic [15:0] index);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_op    <= op;
    req_index <= index;
    @(posedge clk_i);
    while (req_ready !== 1'b1) @(posedge clk_i);
    predict_request(op, index);
  endtask

  task automatic check_basics();
    push_request(OP_ALLOC, 16'h0000);
    push_request(OP_ALLOC, 16'hFFFF);
    push_request(OP_ALLOC, 16'h5A5A);
    push_request(OP_FREE, 16'(FIRST_DATA + 1));
    push_request(OP_FREE, 16'(FIRST_DATA + 1));  // already free
    push_request(OP_FREE, 16'h0000);             // reserved block
    push_request(OP_FREE, 16'(FIRST_DATA - 1));  // just below the data region
    push_request(OP_FREE, 16'hFFFF);             // top block, never granted
    push_request(OP_ALLOC, 16'(FIRST_DATA + 1)); // next fit skips the hole behind
    push_request(OP_ALLOC, 16'hA5A5);
    push_request(OP_FREE, 16'(FIRST_DATA));
    push_request(OP_FREE, 16'(FIRST_DATA + 2));
    push_request(OP_FREE, 16'(FIRST_DATA + 3));
    push_request(OP_FREE, 16'(FIRST_DATA + 4));
    push_request(OP_FREE, 16'hAAAA);
    push_request(OP_FREE, 16'h5555);
    push_request(OP_ALLOC, 16'h8000);
  endtask

  task automatic run_mixed_traffic(input int unsigned count, input int unsigned alloc_pct,
                                   input int unsigned live_pct);
    int unsigned roll;
    int unsigned pick;
    logic [15:0] blk;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 99);
      blk  = 16'($urandom());
      if (roll < alloc_pct || (roll < alloc_pct + live_pct && live_q.size() == 0)) begin
        push_request(OP_ALLOC, blk);
      end else if (roll < alloc_pct + live_pct) begin
        pick         = $urandom_range(0, live_q.size() - 1);
        blk          = live_q[pick];
        live_q[pick] = live_q[live_q.size() - 1];
        void'(live_q.pop_back());
        push_request(OP_FREE, blk);
      end else if (roll < 90) begin
        push_request(OP_FREE, 16'($urandom_range(0, FIRST_DATA - 1)));
      end else if (roll < 96 && freed_q.size() != 0) begin
        push_request(OP_FREE, freed_q[$urandom_range(0, freed_q.size() - 1)]);
      end else begin
        push_request(OP_FREE, blk);
      end
    end
    gaps_on = 1'b1;
  endtask

  task automatic check_back_to_back();
    gaps_on = 1'b0;
    repeat (4) push_request(OP_ALLOC, 16'($urandom()));
    push_request(OP_FREE, 16'hFFFF);
    push_request(OP_FREE, last_grant);  // most recent grant
    push_request(OP_ALLOC, 16'h0000);   // pointer moves on past the hole
    push_request(OP_FREE, 16'(FIRST_DATA));
    push_request(OP_FREE, 16'(FIRST_DATA));
    push_request(OP_ALLOC, 16'h0000);
    push_request(OP_FREE, 16'h8000);
    gaps_on = 1'b1;
  endtask

  initial begin : result_checker
    alloc_result_t want;
    int unsigned   stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = gaps_on ? $urandom_range(0, 15) : 0;
      if (stall != 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ready <= 1'b1;
      @(posedge clk_i);
      while (rsp_valid !== 1'b1) @(posedge clk_i);
      if (expected_q.size() == 0) begin
        $error("result word with nothing outstanding: tdata %h tuser %h", rsp_data, rsp_status);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        status_seen[want.status]++;
        if (rsp_data[15:0] !== want.blk) begin
          $error("granted_block: expected %0d, actual %0d", want.blk, rsp_data[15:0]);
          mismatches++;
        end
        if (rsp_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_status);
          mismatches++;
        end
        if (rsp_data[32:16] !== want.free_left) begin
          $error("free_left: expected %0d, actual %0d", want.free_left, rsp_data[32:16]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #64_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int unsigned settle;
    block_used  = '{default: 1'b0};
    last_grant  = 16'(FIRST_DATA - 1);
    blocks_free = 17'(DATA_BLOCKS);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_basics();
    run_mixed_traffic(380, 45, 35);
    check_back_to_back();
    run_mixed_traffic(150, 40, 35);
    req_valid <= 1'b0;
    for (settle = 0; settle < 200000 && expected_q.size() != 0; settle++) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("requests checked: %0d granted, %0d freed, %0d on an empty pool, %0d rejected frees",
             status_seen[ST_GRANTED], status_seen[ST_FREED], status_seen[ST_EMPTY],
             status_seen[ST_BADFREE]);
    $display("mixed grant and free traffic with reserved, repeated and stale frees, plus a burst");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
